// File: sv/enm_pkg.sv
// Package for the epsilon-NFA matcher: sizes, action codes, payload structs
// and the controller/datapath command and status types. No dependencies.
package enm_pkg;

    localparam int NUM_STATES    = 32;
    localparam int ALPHABET_SIZE = 256;
    localparam int STATE_W       = $clog2(NUM_STATES);
    localparam int SYM_W         = 8;
    localparam int SYM_ADDR_W    = STATE_W + SYM_W;
    localparam int SYM_DEPTH     = NUM_STATES * ALPHABET_SIZE;
    localparam int CFG_IDX_W     = 1;

    localparam logic [1:0] ACT_LOAD_SYM = 2'd0;
    localparam logic [1:0] ACT_LOAD_EPS = 2'd1;
    localparam logic [1:0] ACT_CHAR     = 2'd2;
    localparam logic [1:0] ACT_EMPTY    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_START_STATE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_MASK = 1'd1;

    typedef logic [NUM_STATES-1:0] set_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [4:0]  state_index;
        logic [7:0]  symbol;
        logic [31:0] dest_mask;
        logic        first;
        logic        last;
    } in_item_t;

    typedef struct packed {
        logic accepted;
        logic fell_off;
    } out_item_t;

    typedef struct packed {
        logic load_start;   // active <= start set, dead cleared
        logic close_start;  // begin an epsilon-closure pass
        logic close_round;  // one closure round over all states
        logic step_start;   // clear next set, begin symbol step
        logic step_read;    // issue symbol row read for state counter
        logic step_commit;  // active <= next, set dead if empty
        logic sym_write;
        logic eps_write;
    } dp_cmd_t;

    typedef struct packed {
        logic closed;       // last closure round changed nothing
        logic step_done;    // all state rows read and merged
        logic dead;
        logic hit;          // active meets accept mask
        logic clearing;     // symbol memory clear sweep running
    } dp_stat_t;

endpackage

// File: sv/enm_datapath.sv
// Datapath of the epsilon-NFA matcher: row memories, active set, closure and
// symbol-step logic. Depends on enm_pkg.
module enm_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  enm_pkg::dp_cmd_t                  cmd,
    input  enm_pkg::in_item_t                 item,
    input  logic [enm_pkg::STATE_W-1:0]       start_state,
    input  logic [enm_pkg::NUM_STATES-1:0]    accept_mask,
    output enm_pkg::dp_stat_t                 stat
);
    import enm_pkg::*;

    set_t                  sym_mem [SYM_DEPTH];
    set_t                  eps_reg [NUM_STATES];
    set_t                  active_reg, active_next;
    set_t                  next_reg;
    logic                  dead_reg;
    logic                  closed_reg;
    logic [STATE_W:0]      cnt_reg;
    logic [SYM_ADDR_W:0]   clr_reg;
    logic [SYM_W-1:0]      byte_reg;
    set_t                  rd_data_reg;
    logic                  rd_valid_reg;
    logic                  rd_last_reg;
    set_t                  add;

    always_comb
    begin
        add = '0;
        for (int q = 0; q < NUM_STATES; q++)
        begin
            if (active_reg[q])
                add = add | eps_reg[q];
        end
        active_next = active_reg | add;
    end

    always_ff @(posedge clk)
    begin
        if (clr_reg[SYM_ADDR_W] == 1'b0)
            sym_mem[clr_reg[SYM_ADDR_W-1:0]] <= '0;
        else if (cmd.sym_write)
            sym_mem[{item.state_index, item.symbol}] <= item.dest_mask;
        rd_data_reg <= sym_mem[{cnt_reg[STATE_W-1:0], byte_reg}];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STATES; i++)
                eps_reg[i] <= '0;
            active_reg   <= '0;
            next_reg     <= '0;
            dead_reg     <= 1'b0;
            closed_reg   <= 1'b0;
            cnt_reg      <= '0;
            clr_reg      <= '0;
            byte_reg     <= '0;
            rd_valid_reg <= 1'b0;
            rd_last_reg  <= 1'b0;
        end
        else
        begin
            if (clr_reg[SYM_ADDR_W] == 1'b0)
                clr_reg <= clr_reg + 1'b1;
            if (cmd.eps_write)
                eps_reg[item.state_index] <= item.dest_mask;
            if (cmd.close_round)
                active_reg <= active_next;
            else if (cmd.load_start)
                active_reg <= set_t'(1) << start_state;
            else if (cmd.step_commit)
                active_reg <= next_reg;
            if (cmd.step_start)
                next_reg <= '0;
            else if (rd_valid_reg)
                next_reg <= next_reg | rd_data_reg;
            if (cmd.close_start)
                closed_reg <= 1'b0;
            else if (cmd.close_round)
                closed_reg <= (active_next == active_reg);
            if (cmd.load_start)
                dead_reg <= 1'b0;
            else if (cmd.step_commit && next_reg == '0)
                dead_reg <= 1'b1;
            if (cmd.step_start)
            begin
                cnt_reg  <= '0;
                byte_reg <= item.symbol;
            end
            else if (cmd.step_read && cnt_reg[STATE_W] == 1'b0)
                cnt_reg <= cnt_reg + 1'b1;
            rd_valid_reg <= cmd.step_read && cnt_reg[STATE_W] == 1'b0
                            && active_reg[cnt_reg[STATE_W-1:0]];
            rd_last_reg  <= cmd.step_read && cnt_reg[STATE_W] == 1'b1;
        end
    end

    always_comb
    begin
        stat.closed    = closed_reg;
        stat.step_done = rd_last_reg;
        stat.dead      = dead_reg;
        stat.hit       = (active_reg & accept_mask) != '0;
        stat.clearing  = (clr_reg[SYM_ADDR_W] == 1'b0);
    end

endmodule

// File: sv/enm_ctrl.sv
// Controller of the epsilon-NFA matcher: sequences loads, closure and step,
// drives the input stall and the output register. Depends on enm_pkg.
module enm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  enm_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output enm_pkg::out_item_t  out_data,
    output enm_pkg::in_item_t   item,
    output enm_pkg::dp_cmd_t    cmd,
    input  enm_pkg::dp_stat_t   stat
);
    import enm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_CLOSE, S_STEP, S_COMMIT, S_FINAL, S_REPORT
    } state_t;

    state_t    state_reg;
    in_item_t  item_reg;
    logic      out_valid_reg;
    out_item_t out_reg;
    logic      take;
    logic      out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE) || stat.clearing;
    assign take      = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign item      = take ? in_data : item_reg;

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    cmd.sym_write  = (in_data.action == ACT_LOAD_SYM);
                    cmd.eps_write  = (in_data.action == ACT_LOAD_EPS);
                    cmd.load_start = (in_data.action == ACT_EMPTY)
                                     || (in_data.action == ACT_CHAR && in_data.first);
                    cmd.close_start = (in_data.action == ACT_EMPTY)
                                      || (in_data.action == ACT_CHAR);
                end
            end
            S_CLOSE:
            begin
                cmd.close_round = !stat.closed;
                cmd.step_start  = stat.closed;
            end
            S_STEP:   cmd.step_read   = 1'b1;
            S_COMMIT:
            begin
                cmd.step_commit = 1'b1;
                cmd.close_start = item_reg.last;
            end
            S_FINAL:
            begin
                cmd.close_round = !stat.closed;
            end
            S_REPORT: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            item_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != S_REPORT)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (take)
                    begin
                        item_reg <= in_data;
                        if (in_data.action == ACT_EMPTY)
                            state_reg <= S_FINAL;
                        else if (in_data.action == ACT_CHAR)
                        begin
                            if (stat.dead && !in_data.first)
                                state_reg <= in_data.last ? S_REPORT : S_IDLE;
                            else
                                state_reg <= S_CLOSE;
                        end
                    end
                end
                S_CLOSE:
                begin
                    if (stat.closed)
                        state_reg <= S_STEP;
                end
                S_STEP:
                begin
                    if (stat.step_done)
                        state_reg <= S_COMMIT;
                end
                S_COMMIT:
                begin
                    state_reg <= item_reg.last ? S_FINAL : S_IDLE;
                end
                S_FINAL:
                begin
                    if (stat.closed || stat.dead)
                        state_reg <= S_REPORT;
                end
                S_REPORT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg    <= 1'b1;
                        out_reg.accepted <= !stat.dead && stat.hit;
                        out_reg.fell_off <= stat.dead;
                        state_reg        <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// File: sv/epsilon_nfa_matcher.sv
// Top level of the epsilon-NFA matcher: config registers, controller and
// datapath. Depends on enm_pkg, enm_ctrl, enm_datapath.
//
//  channel | signals                          | moves
//  in      | in_valid, in_stall, in_data      | load, character, empty string
//  out     | out_valid, out_stall, out_data   | accepted, fell_off
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write
//
// A load is written as it is taken. A character runs the closure rounds, then
// the symbol step, which reads one memory row per state. The last byte adds a
// final closure and the report state; an empty string loads the start state,
// then runs closure and report. A byte after the string fell off skips closure and step.
// After reset all 8192 symbol memory rows are cleared; in_stall is high meanwhile.
// A result waiting under out_stall holds the controller in its report state.
module epsilon_nfa_matcher (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  enm_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output enm_pkg::out_item_t            out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [enm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);
    import enm_pkg::*;

    logic [STATE_W-1:0] start_state_reg;
    set_t               accept_mask_reg;
    in_item_t           item;
    dp_cmd_t            cmd;
    dp_stat_t           stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_state_reg <= '0;
            accept_mask_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_START_STATE: start_state_reg <= cfg_data[STATE_W-1:0];
                REG_ACCEPT_MASK: accept_mask_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    enm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .item      (item),
        .cmd       (cmd),
        .stat      (stat)
    );

    enm_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .item        (item),
        .start_state (start_state_reg),
        .accept_mask (accept_mask_reg),
        .stat        (stat)
    );

`ifndef SYNTH
    a_no_take_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        stat.clearing |-> in_stall)
        else $error("input taken during memory clear");
    a_result_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.accepted && out_data.fell_off))
        else $error("accepted and fell_off both set");
    a_commit_after_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step_commit |-> $past(stat.step_done))
        else $error("commit without finished step");
`endif

endmodule

// File: verif/epsilon_nfa_matcher_tb.sv
// Self-checking testbench for epsilon_nfa_matcher: random NFAs and byte strings
// are checked against an in-bench predictor of the active-set simulation.
// Depends on enm_pkg and the epsilon_nfa_matcher RTL.
module epsilon_nfa_matcher_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import enm_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_item_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    epsilon_nfa_matcher i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    set_t sym_rows [SYM_DEPTH];
    set_t eps_rows [NUM_STATES];
    set_t active_set;
    logic dead;
    logic [4:0] start_reg;
    logic [31:0] accept_reg;

    in_item_t pending_items[$];
    out_item_t verdicts_due[$];
    int errors = 0;
    int n_items = 0;
    int n_verdicts = 0;
    int n_accepted = 0;
    int n_fell = 0;
    int cycles = 0;
    logic taken = 1'b0;
    int burst_left = 0;
    int gap_left = 0;

    function automatic void queue_item(in_item_t it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    function automatic set_t eps_closure(set_t s);
        set_t prev;
        set_t add;
        do
        begin
            prev = s;
            add = '0;
            for (int q = 0; q < NUM_STATES; q++)
                if (s[q])
                    add |= eps_rows[q];
            s = s | add;
        end
        while (s != prev);
        return s;
    endfunction

    function automatic set_t sym_step(set_t s, logic [7:0] b);
        set_t nxt;
        nxt = '0;
        for (int q = 0; q < NUM_STATES; q++)
            if (s[q])
                nxt |= sym_rows[{q[4:0], b}];
        return nxt;
    endfunction

    task automatic predict_match(in_item_t it);
        out_item_t r;
        r = '0;
        case (it.action)
            ACT_LOAD_SYM: sym_rows[{it.state_index, it.symbol}] = it.dest_mask;
            ACT_LOAD_EPS: eps_rows[it.state_index] = it.dest_mask;
            ACT_EMPTY:
            begin
                active_set = eps_closure(set_t'(1) << start_reg);
                dead = 1'b0;
                r.accepted = |(active_set & accept_reg);
                verdicts_due.insert(verdicts_due.size(), r);
            end
            default:
            begin
                if (it.first)
                begin
                    active_set = set_t'(1) << start_reg;
                    dead = 1'b0;
                end
                if (!dead)
                begin
                    active_set = sym_step(eps_closure(active_set), it.symbol);
                    if (active_set == '0)
                        dead = 1'b1;
                end
                if (it.last)
                begin
                    if (dead)
                        r.fell_off = 1'b1;
                    else
                    begin
                        active_set = eps_closure(active_set);
                        r.accepted = |(active_set & accept_reg);
                    end
                    verdicts_due.insert(verdicts_due.size(), r);
                end
            end
        endcase
    endtask

    // driver: bursts with random gaps
    always @(negedge clk)
    begin
        if (in_valid && !taken)
            in_valid <= 1'b1;
        else if (gap_left > 0)
        begin
            gap_left <= gap_left - 1;
            in_valid <= 1'b0;
        end
        else if (pending_items.size() > 0)
        begin
            in_valid <= 1'b1;
            in_data <= pending_items.pop_front();
            if (burst_left <= 1)
            begin
                burst_left <= $urandom_range(1, 30);
                gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
            else
                burst_left <= burst_left - 1;
        end
        else
            in_valid <= 1'b0;
    end

    // receiver stall pattern, with one long hold-off
    int stall_mode = 0;
    int mode_left = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;
    always @(negedge clk)
    begin
        if (!hold_done && n_verdicts >= 120)
        begin
            hold_done <= 1'b1;
            hold_left <= 800;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 2);
                mode_left <= $urandom_range(20, 200);
            end
            else
                mode_left <= mode_left - 1;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin
        out_item_t want;
        cycles <= cycles + 1;
        taken <= in_valid && !in_stall;
        if (in_valid && !in_stall)
        begin
            predict_match(in_data);
            n_items <= n_items + 1;
        end
        if (out_valid && !out_stall)
        begin
            n_verdicts <= n_verdicts + 1;
            n_accepted <= n_accepted + out_data.accepted;
            n_fell <= n_fell + out_data.fell_off;
            if (verdicts_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result transaction: %b", out_data);
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (want.accepted !== out_data.accepted || want.fell_off !== out_data.fell_off)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected accepted=%b fell_off=%b, got %b %b",
                                 want.accepted, want.fell_off,
                                 out_data.accepted, out_data.fell_off);
                end
            end
        end
        if (cycles > 2000000)
        begin
            $display("timeout with %0d results outstanding", verdicts_due.size());
            $display("epsilon_nfa_matcher_tb: errors");
            $finish;
        end
    end

    function automatic in_item_t mk(logic [1:0] a, logic [4:0] s, logic [7:0] b,
                                    logic [31:0] d, logic f, logic l);
        in_item_t it;
        it.action = a;
        it.state_index = s;
        it.symbol = b;
        it.dest_mask = d;
        it.first = f;
        it.last = l;
        return it;
    endfunction

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_START_STATE)
            start_reg = val[4:0];
        else
            accept_reg = val;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain;
        wait (pending_items.size() == 0 && !in_valid && verdicts_due.size() == 0);
        repeat (150) @(posedge clk);
    endtask

    function automatic logic [31:0] sparse(int nst);
        logic [31:0] lim;
        lim = (nst >= 32) ? 32'hFFFF_FFFF : ((32'd1 << nst) - 1);
        return $urandom & $urandom & $urandom & lim;
    endfunction

    task automatic random_phase(int count);
        logic [7:0] alpha [4];
        int nst;
        int k;
        int len;
        logic [7:0] b;
        nst = ($urandom_range(0, 3) == 0) ? 32 : $urandom_range(2, 12);
        foreach (alpha[i])
            alpha[i] = 8'($urandom_range(0, 255));
        for (int i = 0; i < 3 * nst + 10; i++)
            queue_item(mk(ACT_LOAD_SYM, 5'($urandom_range(0, nst - 1)),
                          alpha[$urandom_range(0, 3)],
                          ($urandom_range(0, 15) == 0) ? $urandom : sparse(nst),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
        for (int i = 0; i < nst / 3 + 1; i++)
            queue_item(mk(ACT_LOAD_EPS, 5'($urandom_range(0, nst - 1)),
                          8'($urandom), sparse(nst) & sparse(nst),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
        k = 0;
        while (k < count)
        begin
            case ($urandom_range(0, 19))
                0:
                begin
                    queue_item(mk(2'($urandom), 5'($urandom), 8'($urandom), $urandom,
                                  1'($urandom), 1'($urandom)));
                    k++;
                end
                1:
                begin
                    queue_item(mk(ACT_EMPTY, 5'($urandom), 8'($urandom), $urandom,
                                  1'($urandom), 1'($urandom)));
                    k++;
                end
                default:
                begin
                    len = $urandom_range(1, 6);
                    for (int j = 0; j < len; j++)
                    begin
                        if ($urandom_range(0, 9) == 0)
                            b = 8'($urandom);
                        else
                            b = alpha[$urandom_range(0, 3)];
                        queue_item(mk(ACT_CHAR, 5'($urandom), b, $urandom,
                                      j == 0 && $urandom_range(0, 15) != 0,
                                      j == len - 1 && $urandom_range(0, 15) != 0));
                        k++;
                    end
                end
            endcase
        end
    endtask

    initial
    begin
        for (int i = 0; i < SYM_DEPTH; i++)
            sym_rows[i] = '0;
        for (int i = 0; i < NUM_STATES; i++)
            eps_rows[i] = '0;
        active_set = '0;
        dead = 1'b0;
        start_reg = '0;
        accept_reg = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset state, extremes of rows and bytes
        queue_item(mk(ACT_CHAR, 5'd0, 8'h00, 32'h0, 1'b0, 1'b1));
        queue_item(mk(ACT_EMPTY, 5'd0, 8'h00, 32'h0, 1'b0, 1'b0));
        queue_item(mk(ACT_LOAD_SYM, 5'd0, 8'h00, 32'hFFFF_FFFF, 1'b0, 1'b0));
        queue_item(mk(ACT_LOAD_SYM, 5'd31, 8'hFF, 32'h8000_0001, 1'b1, 1'b1));
        queue_item(mk(ACT_LOAD_EPS, 5'd0, 8'hFF, 32'h0000_0020, 1'b1, 1'b0));
        queue_item(mk(ACT_LOAD_EPS, 5'd31, 8'h00, 32'hFFFF_FFFF, 1'b0, 1'b1));
        queue_item(mk(ACT_EMPTY, 5'd31, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1));
        queue_item(mk(ACT_CHAR, 5'd0, 8'h00, 32'h0, 1'b1, 1'b0));
        queue_item(mk(ACT_CHAR, 5'd0, 8'hFF, 32'h0, 1'b0, 1'b0));
        queue_item(mk(ACT_CHAR, 5'd0, 8'h00, 32'h0, 1'b0, 1'b1));
        queue_item(mk(ACT_CHAR, 5'd0, 8'h7F, 32'h0, 1'b1, 1'b1));
        queue_item(mk(ACT_CHAR, 5'd0, 8'h00, 32'h0, 1'b1, 1'b1));
        queue_item(mk(ACT_CHAR, 5'd0, 8'h80, 32'h0, 1'b0, 1'b0));
        queue_item(mk(ACT_CHAR, 5'd0, 8'h00, 32'h0, 1'b0, 1'b1));
        drain();
        cfg_write(REG_ACCEPT_MASK, 32'hFFFF_FFFF);
        cfg_write(REG_START_STATE, 32'd31);
        queue_item(mk(ACT_EMPTY, 5'd0, 8'h00, 32'h0, 1'b0, 1'b0));
        queue_item(mk(ACT_CHAR, 5'd0, 8'hFF, 32'h0, 1'b1, 1'b1));
        queue_item(mk(ACT_CHAR, 5'd0, 8'h00, 32'h0, 1'b1, 1'b0));
        queue_item(mk(ACT_CHAR, 5'd0, 8'hFF, 32'h0, 1'b0, 1'b1));
        drain();

        for (int p = 0; p < 7; p++)
        begin
            cfg_write(REG_START_STATE, p == 0 ? 32'd0 : p == 1 ? 32'd31 : $urandom_range(0, 3));
            cfg_write(REG_ACCEPT_MASK, p == 2 ? 32'h0 : p == 3 ? 32'hFFFF_FFFF : $urandom);
            random_phase(200);
            drain();
        end

        $display("%0d input transactions, %0d results (%0d accepted, %0d fell off)",
                 n_items, n_verdicts, n_accepted, n_fell);
        $display("covered row loads, epsilon closure, dead strings and config extremes");
        if (errors == 0)
            $display("epsilon_nfa_matcher_tb: clean");
        else
            $display("epsilon_nfa_matcher_tb: errors");
        $finish;
    end
endmodule
